### rtl/tncr_pkg.sv
`default_nettype none

package tncr_pkg;

	localparam int FRAC_BITS = 16;

	localparam int IN_W = 24;
	localparam int MANT_W = 31;
	localparam int PROD_W = 2 * MANT_W;
	localparam int EXP_W = 5;
	localparam int LOG_W = FRAC_BITS + 4;
	localparam int DIFF_W = LOG_W + 1;
	localparam int SEMI_W = DIFF_W + 4;
	localparam int NMAG_W = SEMI_W - FRAC_BITS;
	localparam int SEG_W = FRAC_BITS + 6;
	localparam int CNT_W = $clog2(FRAC_BITS + 1);
	localparam int NOTE_W = 9;
	localparam int CLS_W = 4;
	localparam int SEGS_W = 5;
	localparam int TINT_W = 8;
	localparam int HOLD_W = 8;
	localparam int OUT_DATA_W = 32;

	localparam logic [IN_W-1:0] SILENCE_LIMIT = IN_W'(256);
	localparam logic [IN_W-1:0] A4_FREQ_Q8 = IN_W'(440 * 256);
	localparam logic [NOTE_W-1:0] A4_NOTE = NOTE_W'(69);
	localparam logic [NOTE_W-1:0] CLASS_BIAS = NOTE_W'(36);
	localparam logic [SEGS_W-1:0] SEGS_MAX = SEGS_W'(20);
	localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(10);

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_CLEAR  = 2'd1,
		ACT_REDRAW = 2'd2
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_SQ_MUL,
		ST_SQ_NORM,
		ST_FIN_SEMI,
		ST_FIN_ROUND,
		ST_FIN_SEG,
		ST_FIN_TINT,
		ST_DONE
	} state_t;

	function automatic logic [LOG_W-1:0] log2_q8_const(input logic [IN_W-1:0] x);
		logic [63:0] m;
		logic [FRAC_BITS-1:0] frac;
		int p;
		p = 0;
		frac = '0;
		for (int i = 0; i < IN_W; i++) begin
			if (x[i]) begin
				p = i;
			end
		end
		m = 64'(x) << (30 - p);
		for (int i = 0; i < FRAC_BITS; i++) begin
			m = (m * m) >> 30;
			if (m >= 64'h8000_0000) begin
				frac = {frac[FRAC_BITS-2:0], 1'b1};
				m = m >> 1;
			end else begin
				frac = {frac[FRAC_BITS-2:0], 1'b0};
			end
		end
		return {4'(p - 8), frac};
	endfunction

	localparam logic [LOG_W-1:0] LOG2_A4 = log2_q8_const(A4_FREQ_Q8);

endpackage

`default_nettype wire

### rtl/tuner_note_cents_readout_core.sv
// A silent input goes straight from the transaction to the result stage.
// A sounding input is processed in steps: normalizing shifts on the leading one, 16 squarings
// in the shared 31x31 multiplier, then the semitone, rounding, segment and tint stages.
// A new input is accepted only when idle, after the previous result has been loaded for output.
// Reset clears control state and the hold count, last note and last segment count;
// hold_size resets to 10. No clearing pass is needed.
`default_nettype none

module tuner_note_cents_readout_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [tncr_pkg::HOLD_W-1:0] cfg_data,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [tncr_pkg::IN_W-1:0] s_axis_tdata, // frequency_q8
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	// midi_note, note_class, is_flat, segment_count, tint
	output logic [tncr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic [1:0] m_axis_tuser // action
);
	import tncr_pkg::*;

	state_t state_q, state_d;

	logic [HOLD_W-1:0] hold_size_q;
	logic [HOLD_W-1:0] hold_count_q;
	logic [NOTE_W-1:0] last_note_q;
	logic [SEGS_W-1:0] last_segs_q;
	logic last_seen_q;

	logic [MANT_W-1:0] mant_q;
	logic [EXP_W-1:0] exp_q;
	logic [PROD_W-1:0] prod_q;
	logic [CNT_W-1:0] cnt_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic signed [SEMI_W-1:0] semi_q;
	logic [NOTE_W-1:0] note_q;
	logic flat_q;
	logic [FRAC_BITS-1:0] rabs_q;
	logic [SEG_W-1:0] seg_q;
	logic [CLS_W-1:0] cls_q;

	action_t res_action_q;
	logic [NOTE_W-1:0] res_note_q;
	logic [CLS_W-1:0] res_cls_q;
	logic res_flat_q;
	logic [SEGS_W-1:0] res_segs_q;
	logic [TINT_W-1:0] res_tint_q;

	logic out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	action_t out_action_q;

	logic in_xfer, in_silent, out_load;
	logic [HOLD_W-1:0] hold_limit;
	logic [HOLD_W:0] hold_inc;
	logic [MANT_W:0] sq_top;
	logic [LOG_W-1:0] log_val;
	logic signed [DIFF_W-1:0] log_diff;
	logic signed [SEMI_W-1:0] diff_x;
	logic signed [SEMI_W-1:0] semi_val;
	logic semi_neg;
	logic [SEMI_W-1:0] abs_semi;
	logic [SEMI_W-1:0] rnd_semi;
	logic [NMAG_W-1:0] n_mag;
	logic signed [SEMI_W:0] rem;
	logic rem_neg;
	logic [SEMI_W:0] rem_abs;
	logic [NOTE_W-1:0] n9;
	logic [NOTE_W-1:0] note_val;
	logic [NOTE_W-1:0] cls_sum;
	logic [15:0] cls_qprod;
	logic [4:0] cls_div;
	logic [7:0] cls_q12;
	logic [7:0] cls_rem;
	logic [SEG_W-1:0] seg_val;
	logic [SEG_W-FRAC_BITS-1:0] seg_int;
	logic [SEGS_W-1:0] segs_val;
	logic [FRAC_BITS+TINT_W-1:0] tint_prod;
	logic [TINT_W-1:0] tint_val;
	logic redraw;

	assign cfg_ready = 1'b1;
	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign in_silent = s_axis_tdata < SILENCE_LIMIT;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	always_comb begin
		state_d = state_q;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = in_silent ? ST_DONE : ST_NORM;
				end
			end
			ST_NORM: begin
				if (mant_q[MANT_W-1]) begin
					state_d = ST_SQ_MUL;
				end
			end
			ST_SQ_MUL: state_d = ST_SQ_NORM;
			ST_SQ_NORM: begin
				state_d = (cnt_q == CNT_W'(FRAC_BITS - 1)) ? ST_FIN_SEMI : ST_SQ_MUL;
			end
			ST_FIN_SEMI: state_d = ST_FIN_ROUND;
			ST_FIN_ROUND: state_d = ST_FIN_SEG;
			ST_FIN_SEG: state_d = ST_FIN_TINT;
			ST_FIN_TINT: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		hold_limit = (hold_size_q == '0) ? '0 : hold_size_q - HOLD_W'(1);
		hold_inc = {1'b0, hold_count_q} + (HOLD_W + 1)'(1);

		sq_top = prod_q[PROD_W-1:MANT_W-1];

		log_val = {4'(exp_q - EXP_W'(8)), frac_q};
		log_diff = $signed({1'b0, log_val}) - $signed({1'b0, LOG2_A4});
		diff_x = SEMI_W'(log_diff);
		semi_val = (diff_x <<< 3) + (diff_x <<< 2);

		semi_neg = semi_q[SEMI_W-1];
		abs_semi = semi_neg ? SEMI_W'(-semi_q) : SEMI_W'(semi_q);
		rnd_semi = abs_semi + SEMI_W'(1 << (FRAC_BITS - 1));
		n_mag = rnd_semi[SEMI_W-1:FRAC_BITS];
		rem = $signed({1'b0, abs_semi}) - $signed({1'b0, n_mag, {FRAC_BITS{1'b0}}});
		rem_neg = rem[SEMI_W];
		rem_abs = rem_neg ? (SEMI_W + 1)'(-rem) : (SEMI_W + 1)'(rem);
		n9 = NOTE_W'(n_mag);
		note_val = semi_neg ? (A4_NOTE - n9) : (A4_NOTE + n9);

		cls_sum = note_q + CLASS_BIAS;
		cls_qprod = 16'(cls_sum[7:0]) * 16'd171;
		cls_div = cls_qprod[15:11];
		cls_q12 = {cls_div, 3'b000} + {1'b0, cls_div, 2'b00};
		cls_rem = cls_sum[7:0] - cls_q12;

		seg_val = (SEG_W'(rabs_q) << 5) + (SEG_W'(rabs_q) << 3);

		seg_int = seg_q[SEG_W-1:FRAC_BITS];
		segs_val = (seg_int > (SEG_W - FRAC_BITS)'(SEGS_MAX)) ? SEGS_MAX : seg_int[SEGS_W-1:0];
		tint_prod = {seg_q[FRAC_BITS-1:0], {TINT_W{1'b0}}} -
			(FRAC_BITS + TINT_W)'(seg_q[FRAC_BITS-1:0]);
		tint_val = tint_prod[FRAC_BITS+TINT_W-1:FRAC_BITS];
		redraw = !last_seen_q || (note_q != last_note_q) || (segs_val != last_segs_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hold_size_q <= HOLD_RESET;
			hold_count_q <= '0;
			last_note_q <= '0;
			last_segs_q <= '0;
			last_seen_q <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				hold_size_q <= cfg_data;
			end
			if (in_xfer) begin
				if (in_silent) begin
					hold_count_q <= (hold_count_q <= HOLD_W'(1)) ? '0 :
						hold_count_q - HOLD_W'(1);
				end else begin
					hold_count_q <= (hold_inc > {1'b0, hold_limit}) ? hold_limit :
						hold_inc[HOLD_W-1:0];
				end
			end
			if (state_q == ST_NORM) begin
				cnt_q <= '0;
			end else if (state_q == ST_SQ_NORM) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (state_q == ST_FIN_TINT && redraw) begin
				last_note_q <= note_q;
				last_segs_q <= segs_val;
				last_seen_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mant_q <= {s_axis_tdata, {(MANT_W - IN_W){1'b0}}};
				exp_q <= EXP_W'(IN_W - 1);
				frac_q <= '0;
				res_action_q <= (hold_count_q <= HOLD_W'(1)) ? ACT_CLEAR : ACT_NONE;
				res_note_q <= '0;
				res_cls_q <= '0;
				res_flat_q <= 1'b0;
				res_segs_q <= '0;
				res_tint_q <= '0;
			end
			ST_NORM: begin
				if (!mant_q[MANT_W-1]) begin
					mant_q <= {mant_q[MANT_W-2:0], 1'b0};
					exp_q <= exp_q - EXP_W'(1);
				end
			end
			ST_SQ_MUL: prod_q <= PROD_W'(mant_q) * PROD_W'(mant_q);
			ST_SQ_NORM: begin
				if (sq_top[MANT_W]) begin
					mant_q <= sq_top[MANT_W:1];
					frac_q <= {frac_q[FRAC_BITS-2:0], 1'b1};
				end else begin
					mant_q <= sq_top[MANT_W-1:0];
					frac_q <= {frac_q[FRAC_BITS-2:0], 1'b0};
				end
			end
			ST_FIN_SEMI: semi_q <= semi_val;
			ST_FIN_ROUND: begin
				note_q <= note_val;
				flat_q <= (semi_neg && !rem_neg && (rem != '0)) || (!semi_neg && rem_neg);
				rabs_q <= rem_abs[FRAC_BITS-1:0];
			end
			ST_FIN_SEG: begin
				seg_q <= seg_val;
				cls_q <= cls_rem[CLS_W-1:0];
			end
			ST_FIN_TINT: begin
				res_action_q <= redraw ? ACT_REDRAW : ACT_NONE;
				res_note_q <= note_q;
				res_cls_q <= cls_q;
				res_flat_q <= flat_q;
				res_segs_q <= segs_val;
				res_tint_q <= tint_val;
			end
			ST_DONE: begin
				if (out_load) begin
					out_action_q <= res_action_q;
					out_data_q <= OUT_DATA_W'({res_tint_q, res_segs_q, res_flat_q,
						res_cls_q, res_note_q});
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_action_q;

	a_silent_goes_done: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && in_silent) |=> (state_q == ST_DONE))
		else $error("silent transaction did not go straight to the result stage");

	a_hold_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !in_silent) |=> (hold_count_q <= $past(hold_limit)))
		else $error("hold count exceeds its limit after a sounding input");

	a_norm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NORM) |-> (mant_q != '0))
		else $error("normalization running on a zero mantissa");

	a_sq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ_MUL || state_q == ST_SQ_NORM) |-> (cnt_q < CNT_W'(FRAC_BITS)))
		else $error("squaring counter ran past the fraction width");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == ACT_CLEAR) |-> (m_axis_tdata == '0))
		else $error("clear result carries nonzero readout fields");

endmodule

`default_nettype wire
